[rtl/core/pid_pkg.sv]
// Shared constants for the PID step block: field widths, register indexes and mode bits.
// No dependencies.
package pid_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam int FB_W     = 32;
    localparam int DT_W     = 16;
    localparam int ACC_W    = 48;
    localparam int LIM_W    = 47;
    localparam int RANGE_W  = 64;
    localparam int MODE_W   = 5;
    localparam int OUT_W    = 32;

    localparam int MUL_A_W  = 48;
    localparam int MUL_B_W  = 32;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W  = 33;
    localparam int DIV_D_W  = DT_W;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_RANGE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_RANGE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_BITS   = 4'd7;

    localparam int MODE_EN       = 0;
    localparam int MODE_INCLAMP  = 1;
    localparam int MODE_OUTCLAMP = 2;
    localparam int MODE_WRAP     = 3;
    localparam int MODE_TIMED    = 4;

    localparam logic [MODE_W-1:0] MODE_RESET    = 5'd1;
    localparam logic [LIM_W-1:0]  LIMIT_DEFAULT = 47'd300000 << 16;

endpackage

[rtl/core/pid_mul.sv]
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pid_pkg.
module pid_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pid_pkg::MUL_A_W-1:0]    i_a,
    input  logic [pid_pkg::MUL_B_W-1:0]    i_b,
    output logic [pid_pkg::PROD_W-1:0]     o_prod,
    output logic                           o_busy
);
    localparam int CNT_W = $clog2(pid_pkg::MUL_B_W + 1);

    logic [pid_pkg::MUL_A_W-1:0] r_a;
    logic [pid_pkg::MUL_B_W-1:0] r_b;
    logic [pid_pkg::PROD_W-1:0]  r_acc;
    logic [CNT_W-1:0]            r_cnt;
    logic [pid_pkg::MUL_A_W:0]   sum;

    assign sum = {1'b0, r_acc[pid_pkg::PROD_W-1:pid_pkg::MUL_B_W]}
               + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(pid_pkg::MUL_B_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_b   <= r_b >> 1;
            r_acc <= {sum, r_acc[pid_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_prod = r_acc;
    assign o_busy = (r_cnt != '0);
endmodule

[rtl/core/pid_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pid_pkg.
module pid_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pid_pkg::DIV_N_W-1:0]    i_num,
    input  logic [pid_pkg::DIV_D_W-1:0]    i_den,
    output logic [pid_pkg::DIV_N_W-1:0]    o_quot,
    output logic                           o_busy
);
    localparam int CNT_W = $clog2(pid_pkg::DIV_N_W + 1);

    logic [pid_pkg::DIV_D_W-1:0] r_den;
    logic [pid_pkg::DIV_D_W-1:0] r_rem;
    logic [pid_pkg::DIV_N_W-1:0] r_q;
    logic [CNT_W-1:0]            r_cnt;
    logic [pid_pkg::DIV_D_W:0]   trial;
    logic [pid_pkg::DIV_D_W:0]   diff;
    logic                        fits;

    assign trial = {r_rem, r_q[pid_pkg::DIV_N_W-1]};
    assign fits  = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(pid_pkg::DIV_N_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= i_num;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[pid_pkg::DIV_D_W-1:0] : trial[pid_pkg::DIV_D_W-1:0];
            r_q   <= {r_q[pid_pkg::DIV_N_W-2:0], fits};
        end
    end

    assign o_quot = r_q;
    assign o_busy = (r_cnt != '0);
endmodule

[rtl/core/pid_step_with_windup_clamp.sv]
// PID step with integral windup clamp: takes one sample at a time and returns its drive and
// its three terms. The three gain products run one after another through a single
// bit-serial multiplier, each with its own start and capture. Before them a timed item
// waits while the multiplier forms the trapezoid area and the serial divider forms the
// derivative. A result waits in an output register, and a stalled output holds the
// sequencer and so the input. While disabled, an item is taken and dropped. Registers
// are written only while the sequencer is idle.
// Depends on pid_pkg, pid_mul and pid_div.
module pid_step_with_windup_clamp #(
    parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // feedback [31:0], elapsed [47:32]
    input  logic [47:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // drive [31:0], p_term [63:32], i_term [95:64], d_term [127:96]
    output logic [127:0]                      m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pid_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    localparam int DW = DATA_WIDTH;
    localparam int WW = (DW > 32) ? DW : 32;
    localparam int IW = 50;
    localparam int SW = 51;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CLAMP  = 10'b0000000010,
        S_WRAP   = 10'b0000000100,
        S_TSTART = 10'b0000001000,
        S_TWAIT  = 10'b0000010000,
        S_ACC    = 10'b0000100000,
        S_MGO    = 10'b0001000000,
        S_MWAIT  = 10'b0010000000,
        S_SUM    = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        T_PROP  = 2'd0,
        T_INTEG = 2'd1,
        T_DERIV = 2'd2
    } t_term;

    t_state r_state;
    t_term  r_term;

    logic signed [31:0]          r_gp, r_gi, r_gd, r_sp;
    logic [pid_pkg::LIM_W-1:0]   r_limit;
    logic [pid_pkg::RANGE_W-1:0] r_in_range, r_out_range;
    logic [pid_pkg::MODE_W-1:0]  r_mode;

    logic signed [31:0]          r_fb, r_err, r_prev;
    logic [15:0]                 r_dt;
    logic signed [32:0]          r_e0;
    logic signed [pid_pkg::ACC_W-1:0] r_acc;
    logic signed [IW-1:0]        r_inc;
    logic signed [33:0]          r_deriv;
    logic                        r_sneg, r_dneg;
    logic signed [DW-1:0]        r_p, r_i, r_d, r_drive;
    logic [127:0]                r_out;
    logic                        r_ovalid;

    logic signed [31:0] in_lo, in_hi, out_lo, out_hi, fb_c;
    logic signed [32:0] span, diff, tsum;
    logic signed [33:0] c1, c2, e0x, werr;
    logic [33:0]        m0, m1, m2;
    logic [32:0]        diff_mag, tsum_mag;
    logic [31:0]        err_mag, gain_mag;
    logic [47:0]        acc_mag;
    logic [33:0]        der_mag;
    logic               term_neg;
    logic signed [31:0] gain_sel;

    logic                          mul_start, div_start, mul_busy, div_busy;
    logic [pid_pkg::MUL_A_W-1:0]   mul_a;
    logic [pid_pkg::MUL_B_W-1:0]   mul_b;
    logic [pid_pkg::PROD_W-1:0]    prod;
    logic [pid_pkg::DIV_N_W-1:0]   quot;

    logic [63:0]        mq, lim64, mm;
    logic signed [DW-1:0] term_val;
    logic signed [IW-1:0] tinc_mag;
    logic signed [SW-1:0] acc_sum, lim_s, acc_new;
    logic signed [DW+1:0] psum;
    logic signed [DW-1:0] psat;
    logic signed [WW-1:0] dx, drv_c, px, ix, ddx;

    assign in_lo  = r_in_range[31:0];
    assign in_hi  = r_in_range[63:32];
    assign out_lo = r_out_range[31:0];
    assign out_hi = r_out_range[63:32];

    always_comb begin
        fb_c = r_fb;
        if (r_mode[pid_pkg::MODE_INCLAMP]) begin
            if (fb_c > in_hi) fb_c = in_hi;
            if (fb_c < in_lo) fb_c = in_lo;
        end
    end

    assign span = {in_hi[31], in_hi} - {in_lo[31], in_lo};
    assign e0x  = {r_e0[32], r_e0};
    assign c1   = e0x + {span[32], span};
    assign c2   = e0x - {span[32], span};
    assign m0   = e0x[33] ? 34'(-e0x) : 34'(e0x);
    assign m1   = c1[33] ? 34'(-c1) : 34'(c1);
    assign m2   = c2[33] ? 34'(-c2) : 34'(c2);

    always_comb begin
        werr = e0x;
        if (r_mode[pid_pkg::MODE_WRAP] && (in_hi > in_lo)) begin
            if (!((m0 <= m1) && (m0 <= m2))) begin
                werr = (m1 < m2) ? c1 : c2;
            end
        end
    end

    assign diff     = {r_err[31], r_err} - {r_prev[31], r_prev};
    assign tsum     = {r_prev[31], r_prev} + {r_err[31], r_err};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign tsum_mag = tsum[32] ? 33'(-tsum) : 33'(tsum);
    assign err_mag  = r_err[31] ? 32'(-r_err) : 32'(r_err);
    assign acc_mag  = r_acc[47] ? 48'(-r_acc) : 48'(r_acc);
    assign der_mag  = r_deriv[33] ? 34'(-r_deriv) : 34'(r_deriv);

    always_comb begin
        unique case (r_term)
            T_PROP: begin
                gain_sel = r_gp;
                term_neg = r_err[31] ^ r_gp[31];
                mul_a    = {16'b0, err_mag};
            end
            T_INTEG: begin
                gain_sel = r_gi;
                term_neg = r_acc[47] ^ r_gi[31];
                mul_a    = acc_mag;
            end
            default: begin
                gain_sel = r_gd;
                term_neg = r_deriv[33] ^ r_gd[31];
                mul_a    = {14'b0, der_mag};
            end
        endcase
        gain_mag = gain_sel[31] ? 32'(-gain_sel) : 32'(gain_sel);
        mul_b    = gain_mag;
        if (r_state == S_TSTART) begin
            mul_a = {15'b0, tsum_mag};
            mul_b = {16'b0, r_dt};
        end
    end

    assign mul_start = (r_state == S_MGO)
                    || ((r_state == S_TSTART) && r_mode[pid_pkg::MODE_TIMED]);
    assign div_start = (r_state == S_TSTART) && r_mode[pid_pkg::MODE_TIMED];

    pid_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (prod),
        .o_busy  (mul_busy)
    );

    pid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (diff_mag),
        .i_den   (r_dt),
        .o_quot  (quot),
        .o_busy  (div_busy)
    );

    assign mq       = prod[79:16];
    assign lim64    = (64'd1 << (DW - 1)) - {63'b0, !term_neg};
    assign mm       = (mq > lim64) ? lim64 : mq;
    assign term_val = term_neg ? DW'(-mm) : DW'(mm);

    assign tinc_mag = IW'(prod[49:1]);
    assign lim_s    = SW'({1'b0, r_limit});
    assign acc_sum  = SW'(r_acc) + SW'(r_inc);

    always_comb begin
        acc_new = acc_sum;
        if (acc_new > lim_s)  acc_new = lim_s;
        if (acc_new < -lim_s) acc_new = -lim_s;
    end

    assign psum = (DW+2)'(r_p) + (DW+2)'(r_i) + (DW+2)'(r_d);

    always_comb begin
        if (psum > $signed((DW+2)'({1'b0, {(DW-1){1'b1}}}))) begin
            psat = {1'b0, {(DW-1){1'b1}}};
        end else if (psum < -$signed((DW+2)'({1'b1, {(DW-1){1'b0}}}))) begin
            psat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            psat = psum[DW-1:0];
        end
    end

    assign dx = WW'(r_drive);
    always_comb begin
        drv_c = dx;
        if (r_mode[pid_pkg::MODE_OUTCLAMP]) begin
            if (drv_c > WW'(out_hi)) drv_c = WW'(out_hi);
            if (drv_c < WW'(out_lo)) drv_c = WW'(out_lo);
        end
    end
    assign px  = WW'(r_p);
    assign ix  = WW'(r_i);
    assign ddx = WW'(r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp        <= '0;
            r_gi        <= '0;
            r_gd        <= '0;
            r_sp        <= '0;
            r_limit     <= pid_pkg::LIMIT_DEFAULT;
            r_in_range  <= '0;
            r_out_range <= '0;
            r_mode      <= pid_pkg::MODE_RESET;
            r_state     <= S_IDLE;
            r_term      <= T_PROP;
            r_prev      <= '0;
            r_acc       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    pid_pkg::CFG_GAIN_PROP:   r_gp <= i_cfg_data[31:0];
                    pid_pkg::CFG_GAIN_INTEG:  r_gi <= i_cfg_data[31:0];
                    pid_pkg::CFG_GAIN_DERIV:  r_gd <= i_cfg_data[31:0];
                    pid_pkg::CFG_SETPOINT:    r_sp <= i_cfg_data[31:0];
                    pid_pkg::CFG_INTEG_LIMIT: r_limit <= i_cfg_data[pid_pkg::LIM_W-1:0];
                    pid_pkg::CFG_IN_RANGE:    r_in_range <= i_cfg_data;
                    pid_pkg::CFG_OUT_RANGE:   r_out_range <= i_cfg_data;
                    pid_pkg::CFG_MODE_BITS: begin
                        r_mode <= i_cfg_data[pid_pkg::MODE_W-1:0];
                        if (!i_cfg_data[pid_pkg::MODE_EN]) r_acc <= '0;
                    end
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready && r_mode[pid_pkg::MODE_EN]) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    r_state <= S_TSTART;
                end
                S_TSTART: begin
                    r_state <= r_mode[pid_pkg::MODE_TIMED] ? S_TWAIT : S_ACC;
                end
                S_TWAIT: begin
                    if (!mul_busy && !div_busy) r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= acc_new[pid_pkg::ACC_W-1:0];
                    r_term  <= T_PROP;
                    r_state <= S_MGO;
                end
                S_MGO: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (!mul_busy) begin
                        unique case (r_term)
                            T_PROP: begin
                                r_term  <= T_INTEG;
                                r_state <= S_MGO;
                            end
                            T_INTEG: begin
                                r_term  <= T_DERIV;
                                r_state <= S_MGO;
                            end
                            default: begin
                                r_state <= S_SUM;
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    r_prev  <= r_err;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_fb <= s_axis_tdata[31:0];
            r_dt <= s_axis_tdata[47:32];
        end
        if (r_state == S_CLAMP) begin
            r_e0 <= {r_sp[31], r_sp} - {fb_c[31], fb_c};
        end
        if (r_state == S_WRAP) begin
            if (werr > 34'sd2147483647) begin
                r_err <= 32'sh7fffffff;
            end else if (werr < -34'sd2147483648) begin
                r_err <= 32'sh80000000;
            end else begin
                r_err <= werr[31:0];
            end
        end
        if (r_state == S_TSTART) begin
            r_sneg  <= tsum[32];
            r_dneg  <= diff[32];
            r_inc   <= IW'(r_err);
            r_deriv <= 34'(diff);
        end
        if ((r_state == S_TWAIT) && !mul_busy && !div_busy) begin
            r_inc <= r_sneg ? -tinc_mag : tinc_mag;
            if (r_dt == '0) begin
                r_deriv <= '0;
            end else begin
                r_deriv <= r_dneg ? -34'({1'b0, quot}) : 34'({1'b0, quot});
            end
        end
        if ((r_state == S_MWAIT) && !mul_busy) begin
            unique case (r_term)
                T_PROP:  r_p <= term_val;
                T_INTEG: r_i <= term_val;
                default: r_d <= term_val;
            endcase
        end
        if (r_state == S_SUM) begin
            r_drive <= psat;
        end
        if ((r_state == S_OUT) && (!r_ovalid || m_axis_tready)) begin
            r_out <= {ddx[31:0], ix[31:0], px[31:0], drv_c[31:0]};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign o_cfg_ready   = (r_state == S_IDLE);

endmodule
